>>> rtl/mvd_pkg.sv
// shared types, widths and constants for the masked vector distance block
`default_nettype none
package mvd_pkg;
	localparam int FRAC_BITS    = 8;
	localparam int MAX_ELEMENTS = 1024;
	localparam int COUNT_LIMIT  = 2047;

	localparam int VAL_W   = 16;
	localparam int W_SD    = 45;
	localparam int W_SP    = 48;
	localparam int W_SF    = 28;
	localparam int W_SQ    = 41;
	localparam int W_CNT   = 11;
	localparam int DIST_W  = 40;
	localparam int OP_W    = 53;
	localparam int SG_W    = OP_W + 1;
	localparam int PROD_W  = 2 * OP_W;
	localparam int RAD_W   = 108;
	localparam int ROOT_W  = RAD_W / 2;
	localparam int REM_W   = ROOT_W + 4;
	localparam int Q_BITS  = 16;
	localparam int SQ_STEPS = RAD_W / 2;
	localparam int SD_CW   = $clog2(SQ_STEPS + 1);
	localparam int SQ_SHIFT = 32 - 2 * FRAC_BITS;
	localparam int M_SHIFT  = 16 - FRAC_BITS;
	localparam int MAN_W    = W_SD + 16;
	localparam int OP_CW    = 3;

	localparam logic [1:0] MET_EUCLID    = 2'd0;
	localparam logic [1:0] MET_MANHATTAN = 2'd1;

	localparam logic [DIST_W-1:0] ONE_Q16 = DIST_W'(65536);
	localparam logic [DIST_W-1:0] TWO_Q16 = DIST_W'(131072);

	typedef enum logic [1:0] {
		SQ_ROOT,
		SQ_DIV
	} sq_mode_t;

	typedef struct packed {
		logic     start;
		sq_mode_t mode;
	} sq_ctl_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EISS,
		S_EWAIT,
		S_FINAL,
		S_PISS,
		S_PWAIT,
		S_PCHK,
		S_SQISS,
		S_SQWAIT,
		S_DVCHK,
		S_DVISS,
		S_DVWAIT,
		S_DONE
	} state_t;

	function automatic logic [OP_W-1:0] mag(input logic signed [SG_W-1:0] v);
		logic signed [SG_W-1:0] t;
		t = v[SG_W-1] ? -v : v;
		return t[OP_W-1:0];
	endfunction
endpackage
`default_nettype wire

>>> rtl/mvd_if.sv
// item, result and configuration channel interfaces
`default_nettype none
interface mvd_item_if;
	logic                    valid;
	logic                    ready;
	logic signed [15:0]      x_value;
	logic signed [15:0]      y_value;
	logic                    x_null;
	logic                    y_null;
	logic                    last_element;
	modport source(output valid, x_value, y_value, x_null, y_null, last_element, input ready);
	modport sink(input valid, x_value, y_value, x_null, y_null, last_element, output ready);
endinterface

interface mvd_res_if;
	logic        valid;
	logic        ready;
	logic [39:0] distance;
	logic        empty_res;
	logic        degenerate;
	logic [10:0] pair_count;
	modport source(output valid, distance, empty_res, degenerate, pair_count, input ready);
	modport sink(input valid, distance, empty_res, degenerate, pair_count, output ready);
endinterface

interface mvd_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] metric;
	modport source(output valid, metric, input ready);
	modport sink(input valid, metric, output ready);
endinterface
`default_nettype wire

>>> rtl/mvd_mul.sv
// shift-add multiplier, one multiplier bit per cycle, stops when the multiplier runs out
`default_nettype none
module mvd_mul import mvd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [OP_W-1:0]   a,
	input  wire logic [OP_W-1:0]   b,
	output logic                   done,
	output logic [PROD_W-1:0]      prod
);
	logic              busy_q;
	logic              done_q;
	logic [PROD_W-1:0] a_q;
	logic [OP_W-1:0]   b_q;
	logic [PROD_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && b_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= PROD_W'(a);
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q && b_q != '0) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= a_q << 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule
`default_nettype wire

>>> rtl/mvd_sqdiv.sv
// bit-serial square root and restoring divide sharing one compare and subtract
`default_nettype none
module mvd_sqdiv import mvd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sq_ctl_t           ctl,
	input  wire logic [RAD_W-1:0]  radicand,
	input  wire logic [OP_W-1:0]   dividend,
	input  wire logic [ROOT_W-1:0] divisor,
	output logic                   done,
	output logic [ROOT_W-1:0]      result
);
	logic              busy_q;
	logic              done_q;
	logic [SD_CW-1:0]  cnt_q;
	sq_mode_t          mode_q;
	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W-1:0] dsr_q;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic [REM_W-1:0]  diff;
	logic              ge;

	always_comb begin
		if (mode_q == SQ_ROOT) begin
			rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
			trial  = REM_W'({root_q, 2'b01});
		end else begin
			rem_sh = {rem_q[REM_W-2:0], 1'b0};
			trial  = REM_W'(dsr_q);
		end
		ge   = rem_sh >= trial;
		diff = rem_sh - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= (ctl.mode == SQ_ROOT) ? SD_CW'(SQ_STEPS) : SD_CW'(Q_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SD_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mode_q <= ctl.mode;
			rad_q  <= radicand;
			rem_q  <= (ctl.mode == SQ_DIV) ? REM_W'(dividend) : '0;
			root_q <= '0;
			dsr_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= ge ? diff : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], ge};
			rad_q  <= rad_q << 2;
		end
	end

	assign done   = done_q;
	assign result = root_q;
endmodule
`default_nettype wire

>>> rtl/masked_vector_distance.sv
// masked vector distance top level: accumulators, sequencer and result register
// Element pairs enter one at a time. A pair with a null element is skipped. A present pair
// runs four products through the shared shift-add multiplier, each running until its
// multiplier operand has no set bits left. The pair marked last then closes the vectors:
// manhattan finishes directly, euclidean adds a 54-step square root, pearson adds six
// products of the sums, their variance product, the 54-step root and a 16-step divide.
// The result waits in an output register, so the next vector can start while it is held.
`default_nettype none
module masked_vector_distance import mvd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	mvd_cfg_if.sink    cfg,
	mvd_item_if.sink   items,
	mvd_res_if.source  results
);
	state_t state_q, state_d;

	logic [1:0]                metric_q;
	logic [W_SD-1:0]           sum_diff_q;
	logic signed [W_SP-1:0]    sum_products_q;
	logic signed [W_SF-1:0]    sum_first_q;
	logic signed [W_SF-1:0]    sum_second_q;
	logic [W_SQ-1:0]           sum_first_squares_q;
	logic [W_SQ-1:0]           sum_second_squares_q;
	logic [W_CNT-1:0]          valid_pairs_q;
	logic [OP_CW-1:0]          op_q;
	logic                      res_valid_q;

	logic signed [VAL_W-1:0]   x_q, y_q;
	logic                      last_q;
	logic                      neg_q;
	logic signed [SG_W-1:0]    tmp_q, num_q, d1_q, d2_q;
	logic [RAD_W-1:0]          rad_q;
	logic [ROOT_W-1:0]         s_q;
	logic [DIST_W-1:0]         dist_q;
	logic                      empty_q, degen_q;
	logic [DIST_W-1:0]         out_dist_q;
	logic                      out_empty_q, out_degen_q;
	logic [W_CNT-1:0]          out_count_q;

	logic                      in_acc, take_pair, out_free, is_pearson, empty_now;
	logic                      mul_start, mul_done, mul_neg;
	logic [OP_W-1:0]           mul_a, mul_b;
	logic [PROD_W-1:0]         mul_prod;
	logic signed [SG_W-1:0]    p_s;
	sq_ctl_t                   sq_ctl;
	logic                      sq_done;
	logic [ROOT_W-1:0]         sq_res;
	logic signed [SG_W-1:0]    xs, ys, dd, sps, sfs1, sss1;
	logic [OP_W-1:0]           n53, num_mag;
	logic [MAN_W-1:0]          man_wide;
	logic                      degen_now, q_full;

	assign in_acc     = items.valid && items.ready;
	assign out_free   = !res_valid_q || results.ready;
	assign is_pearson = (metric_q != MET_EUCLID) && (metric_q != MET_MANHATTAN);
	assign empty_now  = (valid_pairs_q == '0);
	assign take_pair  = !items.x_null && !items.y_null
		&& (int'(valid_pairs_q) < MAX_ELEMENTS) && (int'(valid_pairs_q) < COUNT_LIMIT);

	assign xs   = SG_W'(x_q);
	assign ys   = SG_W'(y_q);
	assign dd   = xs - ys;
	assign sps  = SG_W'(sum_products_q);
	assign sfs1 = SG_W'(sum_first_q);
	assign sss1 = SG_W'(sum_second_q);
	assign n53  = OP_W'(valid_pairs_q);
	assign num_mag   = mag(num_q);
	assign man_wide  = MAN_W'(sum_diff_q) << M_SHIFT;
	assign degen_now = (d1_q <= 0) || (d2_q <= 0);
	assign q_full    = (s_q == '0) || ({1'b0, num_mag} >= s_q);
	assign p_s = neg_q ? -$signed(mul_prod[SG_W-1:0]) : $signed(mul_prod[SG_W-1:0]);

	// operand select for the shared multiplier
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_neg = 1'b0;
		if (state_q == S_EISS) begin
			case (op_q)
				3'd0: begin
					mul_a = mag(dd);
					mul_b = (metric_q == MET_MANHATTAN) ? OP_W'(1) : mag(dd);
				end
				3'd1: begin
					mul_a = mag(xs);
					mul_b = mag(xs);
				end
				3'd2: begin
					mul_a = mag(ys);
					mul_b = mag(ys);
				end
				default: begin
					mul_a   = mag(xs);
					mul_b   = mag(ys);
					mul_neg = x_q[VAL_W-1] ^ y_q[VAL_W-1];
				end
			endcase
		end else begin
			case (op_q)
				3'd0: begin
					mul_a   = mag(sps);
					mul_b   = n53;
					mul_neg = sum_products_q[W_SP-1];
				end
				3'd1: begin
					mul_a   = mag(sfs1);
					mul_b   = mag(sss1);
					mul_neg = sum_first_q[W_SF-1] ^ sum_second_q[W_SF-1];
				end
				3'd2: begin
					mul_a = OP_W'(sum_first_squares_q);
					mul_b = n53;
				end
				3'd3: begin
					mul_a = mag(sfs1);
					mul_b = mag(sfs1);
				end
				3'd4: begin
					mul_a = OP_W'(sum_second_squares_q);
					mul_b = n53;
				end
				3'd5: begin
					mul_a = mag(sss1);
					mul_b = mag(sss1);
				end
				default: begin
					mul_a = d1_q[OP_W-1:0];
					mul_b = d2_q[OP_W-1:0];
				end
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (take_pair) state_d = S_EISS;
					else if (items.last_element) state_d = S_FINAL;
				end
			end
			S_EISS: state_d = S_EWAIT;
			S_EWAIT: begin
				if (mul_done && op_q == OP_CW'(3)) state_d = last_q ? S_FINAL : S_IDLE;
				else if (mul_done) state_d = S_EISS;
			end
			S_FINAL: begin
				if (is_pearson) state_d = S_PISS;
				else if (empty_now) state_d = S_DONE;
				else if (metric_q == MET_EUCLID) state_d = S_SQISS;
				else state_d = S_DONE;
			end
			S_PISS: state_d = S_PWAIT;
			S_PWAIT: begin
				if (mul_done) begin
					if (op_q == OP_CW'(5)) state_d = S_PCHK;
					else if (op_q == OP_CW'(6)) state_d = S_SQISS;
					else state_d = S_PISS;
				end
			end
			S_PCHK: state_d = degen_now ? S_DONE : S_PISS;
			S_SQISS: state_d = S_SQWAIT;
			S_SQWAIT: begin
				if (sq_done) state_d = (metric_q == MET_EUCLID) ? S_DONE : S_DVCHK;
			end
			S_DVCHK: state_d = q_full ? S_DONE : S_DVISS;
			S_DVISS: state_d = S_DVWAIT;
			S_DVWAIT: begin
				if (sq_done) state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		items.ready = (state_q == S_IDLE);
		mul_start   = (state_q == S_EISS) || (state_q == S_PISS);
		sq_ctl.start = (state_q == S_SQISS) || (state_q == S_DVISS);
		sq_ctl.mode  = (state_q == S_DVISS) ? SQ_DIV : SQ_ROOT;
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q              <= S_IDLE;
			metric_q             <= MET_EUCLID;
			op_q                 <= '0;
			res_valid_q          <= 1'b0;
			sum_diff_q           <= '0;
			sum_products_q       <= '0;
			sum_first_q          <= '0;
			sum_second_q         <= '0;
			sum_first_squares_q  <= '0;
			sum_second_squares_q <= '0;
			valid_pairs_q        <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) metric_q <= cfg.metric;
			if (results.ready && !(state_q == S_DONE && out_free)) res_valid_q <= 1'b0;
			if (state_q == S_IDLE && in_acc) op_q <= '0;
			if (state_q == S_FINAL) op_q <= '0;
			if ((state_q == S_EWAIT || state_q == S_PWAIT) && mul_done) op_q <= op_q + 1'b1;
			if (state_q == S_EWAIT && mul_done) begin
				case (op_q)
					3'd0: sum_diff_q <= sum_diff_q + p_s[W_SD-1:0];
					3'd1: sum_first_squares_q <= sum_first_squares_q + p_s[W_SQ-1:0];
					3'd2: sum_second_squares_q <= sum_second_squares_q + p_s[W_SQ-1:0];
					default: begin
						sum_products_q <= sum_products_q + p_s[W_SP-1:0];
						sum_first_q    <= sum_first_q + W_SF'(x_q);
						sum_second_q   <= sum_second_q + W_SF'(y_q);
						valid_pairs_q  <= valid_pairs_q + 1'b1;
					end
				endcase
			end
			if (state_q == S_DONE && out_free) begin
				res_valid_q          <= 1'b1;
				sum_diff_q           <= '0;
				sum_products_q       <= '0;
				sum_first_q          <= '0;
				sum_second_q         <= '0;
				sum_first_squares_q  <= '0;
				sum_second_squares_q <= '0;
				valid_pairs_q        <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_acc) begin
			x_q    <= items.x_value;
			y_q    <= items.y_value;
			last_q <= items.last_element;
		end
		if (mul_start) neg_q <= mul_neg;
		if (state_q == S_PWAIT && mul_done) begin
			case (op_q)
				3'd1: num_q <= tmp_q - p_s;
				3'd3: d1_q  <= tmp_q - p_s;
				3'd5: d2_q  <= tmp_q - p_s;
				3'd6: rad_q <= RAD_W'(mul_prod);
				default: tmp_q <= p_s;
			endcase
		end
		if (state_q == S_FINAL) begin
			empty_q <= empty_now;
			degen_q <= 1'b0;
			rad_q   <= RAD_W'(sum_diff_q) << SQ_SHIFT;
			if (empty_now) dist_q <= '1;
			else if (|man_wide[MAN_W-1:DIST_W]) dist_q <= '1;
			else dist_q <= man_wide[DIST_W-1:0];
		end
		if (state_q == S_PCHK && degen_now) begin
			degen_q <= 1'b1;
			dist_q  <= TWO_Q16;
		end
		if (state_q == S_SQWAIT && sq_done) begin
			s_q <= sq_res;
			if (|sq_res[ROOT_W-1:DIST_W]) dist_q <= '1;
			else dist_q <= sq_res[DIST_W-1:0];
		end
		// correlation magnitude reaches one
		if (state_q == S_DVCHK) dist_q <= num_q[SG_W-1] ? TWO_Q16 : '0;
		if (state_q == S_DVWAIT && sq_done) begin
			dist_q <= num_q[SG_W-1] ? ONE_Q16 + DIST_W'(sq_res[Q_BITS-1:0])
				: ONE_Q16 - DIST_W'(sq_res[Q_BITS-1:0]);
		end
		if (state_q == S_DONE && out_free) begin
			out_dist_q  <= dist_q;
			out_empty_q <= empty_q;
			out_degen_q <= degen_q;
			out_count_q <= valid_pairs_q;
		end
	end

	mvd_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	mvd_sqdiv u_sqdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (sq_ctl),
		.radicand (rad_q),
		.dividend (num_mag),
		.divisor  (s_q),
		.done     (sq_done),
		.result   (sq_res)
	);

	assign results.valid      = res_valid_q;
	assign results.distance   = out_dist_q;
	assign results.empty_res  = out_empty_q;
	assign results.degenerate = out_degen_q;
	assign results.pair_count = out_count_q;

`ifndef NO_ASSERTIONS
	a_degen_two: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.degenerate |-> results.distance == TWO_Q16)
		else $error("degenerate result not 2.0");
	a_empty_ones: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.empty_res && !results.degenerate
		|-> results.distance == {DIST_W{1'b1}})
		else $error("empty result not all ones");
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && !results.empty_res |-> results.pair_count != '0)
		else $error("non-empty result with zero pairs");
	a_load_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(results.valid) |-> $past(state_q == S_DONE))
		else $error("result raised outside done state");
`endif
endmodule
`default_nettype wire

>>> sim/masked_vector_distance_checker.sv
// checker: watches the channels, predicts each distance result and compares it
`timescale 1ns / 100ps
module masked_vector_distance_checker import mvd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	mvd_cfg_if        cfg,
	mvd_item_if       items,
	mvd_res_if        results,
	output int        errors,
	output int        outstanding
);
	typedef struct {
		logic [DIST_W-1:0] distance;
		logic              empty_res;
		logic              degenerate;
		logic [W_CNT-1:0]  pair_count;
	} dist_result_t;

	dist_result_t expected_dist[$];

	logic [1:0]   metric_sel;
	longint unsigned diff_acc;
	longint          prod_acc, x_acc, y_acc;
	longint unsigned xsq_acc, ysq_acc;
	int unsigned     pairs_used;

	assign outstanding = expected_dist.size();

	function automatic logic [127:0] floor_sqrt(input logic [127:0] v);
		logic [127:0] root, rem, trial;
		root = 0;
		rem = 0;
		for (int i = 63; i >= 0; i--) begin
			rem = (rem << 2) | ((v >> (2 * i)) & 128'd3);
			trial = (root << 2) | 128'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root << 1) | 128'd1;
			end else begin
				root = root << 1;
			end
		end
		return root;
	endfunction

	function automatic void pearson_dist(output logic [DIST_W-1:0] d, output logic degen);
		logic signed [127:0] n, num, d1, d2;
		logic [127:0] s, a, q;
		n = pairs_used;
		num = n * 128'(signed'(prod_acc)) - 128'(signed'(x_acc)) * 128'(signed'(y_acc));
		d1 = n * $signed({64'd0, xsq_acc}) - 128'(signed'(x_acc)) * 128'(signed'(x_acc));
		d2 = n * $signed({64'd0, ysq_acc}) - 128'(signed'(y_acc)) * 128'(signed'(y_acc));
		if (d1 <= 0 || d2 <= 0) begin
			degen = 1'b1;
			d = TWO_Q16;
			return;
		end
		degen = 1'b0;
		s = floor_sqrt(d1 * d2);
		a = (num < 0) ? -num : num;
		if (s == 0 || a >= s)
			q = 128'd65536;
		else
			q = (a << 16) / s;
		d = (num >= 0) ? DIST_W'(128'd65536 - q) : DIST_W'(128'd65536 + q);
	endfunction

	function automatic void clear_sums();
		diff_acc = 0;
		prod_acc = 0;
		x_acc = 0;
		y_acc = 0;
		xsq_acc = 0;
		ysq_acc = 0;
		pairs_used = 0;
	endfunction

	task automatic take_pair(input logic signed [15:0] x, input logic signed [15:0] y,
			input logic xn, input logic yn, input logic lst);
		longint xv, yv, dv;
		logic [127:0] wide;
		dist_result_t r;
		xv = x;
		yv = y;
		if (!xn && !yn && pairs_used < MAX_ELEMENTS && pairs_used < COUNT_LIMIT) begin
			dv = xv - yv;
			if (dv < 0)
				dv = -dv;
			diff_acc += (metric_sel == MET_MANHATTAN) ? dv : dv * dv;
			prod_acc += xv * yv;
			x_acc += xv;
			y_acc += yv;
			xsq_acc += xv * xv;
			ysq_acc += yv * yv;
			pairs_used++;
		end
		if (!lst)
			return;
		r.empty_res = (pairs_used == 0);
		r.degenerate = 1'b0;
		if (metric_sel >= 2) begin
			pearson_dist(r.distance, r.degenerate);
		end else if (r.empty_res) begin
			r.distance = '1;
		end else begin
			if (metric_sel == MET_EUCLID)
				wide = floor_sqrt({64'd0, diff_acc} << SQ_SHIFT);
			else
				wide = {64'd0, diff_acc} << M_SHIFT;
			r.distance = (wide > 128'hFF_FFFF_FFFF) ? '1 : wide[DIST_W-1:0];
		end
		r.pair_count = W_CNT'(pairs_used);
		expected_dist = {expected_dist, r};
		clear_sums();
	endtask

	always @(posedge clk or negedge arst_n) begin
		dist_result_t e;
		if (!arst_n) begin
			metric_sel = MET_EUCLID;
			clear_sums();
			errors = 0;
		end else begin
			if (cfg.valid && cfg.ready)
				metric_sel = cfg.metric;
			if (items.valid && items.ready)
				take_pair(items.x_value, items.y_value, items.x_null, items.y_null,
					items.last_element);
			if (results.valid && results.ready) begin
				if (expected_dist.size() == 0) begin
					$error("unexpected result, distance %0d", results.distance);
					errors++;
				end else begin
					e = expected_dist.pop_front();
					if (results.distance !== e.distance) begin
						$error("distance: expected %0d, got %0d", e.distance, results.distance);
						errors++;
					end
					if (results.empty_res !== e.empty_res) begin
						$error("empty_res: expected %0d, got %0d", e.empty_res,
							results.empty_res);
						errors++;
					end
					if (results.degenerate !== e.degenerate) begin
						$error("degenerate: expected %0d, got %0d", e.degenerate,
							results.degenerate);
						errors++;
					end
					if (results.pair_count !== e.pair_count) begin
						$error("pair_count: expected %0d, got %0d", e.pair_count,
							results.pair_count);
						errors++;
					end
				end
			end
		end
	end
endmodule

>>> sim/masked_vector_distance_tb.sv
// testbench top: clock, reset, item and configuration stimulus, result drain and verdict
`timescale 1ns / 100ps
module masked_vector_distance_tb;
	import mvd_pkg::*;

	localparam int IDLE_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   errors, outstanding;
	bit   calm = 1'b0;
	bit   hold_req = 1'b0;
	int   hold_cnt = 0;
	int   rx_wait = 0;
	int   idle_cycles = 0;

	mvd_cfg_if  cfg_ch();
	mvd_item_if items_ch();
	mvd_res_if  res_ch();

	masked_vector_distance dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.items(items_ch),
		.results(res_ch)
	);

	masked_vector_distance_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_ch),
		.items(items_ch),
		.results(res_ch),
		.errors(errors),
		.outstanding(outstanding)
	);

	always #10 clk = ~clk;

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 13);
	endfunction

	// stretches with no idling on either side
	always @(posedge clk) begin
		if ($urandom_range(0, 299) == 0)
			calm <= ~calm;
	end

	// result receiver with random stalls and one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (hold_req) begin
				hold_req = 1'b0;
				hold_cnt = 2000;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				res_ch.ready <= 1'b0;
			end else if (res_ch.valid && res_ch.ready) begin
				rx_wait = draw_gap();
				res_ch.ready <= (rx_wait == 0);
			end else if (rx_wait > 0) begin
				rx_wait--;
				res_ch.ready <= (rx_wait == 0);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no accepted item or result
	always @(posedge clk) begin
		if ((items_ch.valid && items_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("masked_vector_distance regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic put_pair(input logic signed [15:0] x, input logic signed [15:0] y,
			input bit xn, input bit yn, input bit lst);
		int w;
		w = draw_gap();
		if (w > 0) begin
			items_ch.valid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		items_ch.valid <= 1'b1;
		items_ch.x_value <= x;
		items_ch.y_value <= y;
		items_ch.x_null <= xn;
		items_ch.y_null <= yn;
		items_ch.last_element <= lst;
		do @(posedge clk); while (!items_ch.ready);
	endtask

	task automatic set_metric(input logic [1:0] m);
		items_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		// a trailing pair with no result may still be in flight
		repeat (300) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.metric <= m;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 16'h7FFF;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'($urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic directed_vectors();
		put_pair(16'sh7FFF, -16'sh8000, 0, 0, 1);
		put_pair(16'sd256, 16'sd256, 1, 0, 0);
		put_pair(16'sd3, 16'sd7, 0, 1, 1);
		put_pair(-16'sh8000, 16'sh7FFF, 0, 0, 0);
		put_pair(16'sd100, -16'sd50, 0, 0, 0);
		put_pair(16'sd0, 16'sd0, 1, 1, 1);
	endtask

	task automatic pearson_vectors();
		// constant first vector, correlated, anticorrelated, single pair, empty vector
		put_pair(16'sd5, 16'sd1, 0, 0, 0);
		put_pair(16'sd5, 16'sd9, 0, 0, 1);
		put_pair(16'sd1, 16'sd2, 0, 0, 0);
		put_pair(16'sd2, 16'sd4, 0, 0, 0);
		put_pair(16'sd3, 16'sd7, 0, 0, 1);
		put_pair(16'sh7FFF, -16'sh8000, 0, 0, 0);
		put_pair(-16'sh8000, 16'sh7FFF, 0, 0, 1);
		put_pair(16'sd9, 16'sd9, 0, 0, 1);
		put_pair(16'sd9, 16'sd9, 0, 1, 1);
	endtask

	task automatic random_vectors(input int n_items);
		int len;
		while (n_items > 0) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
			for (int i = 0; i < len; i++)
				put_pair(pick_value(), pick_value(), $urandom_range(0, 7) == 0,
					$urandom_range(0, 7) == 0, i == len - 1);
			n_items -= len;
		end
	endtask

	initial begin
		cfg_ch.valid = 1'b0;
		cfg_ch.metric = MET_EUCLID;
		items_ch.valid = 1'b0;
		items_ch.x_value = '0;
		items_ch.y_value = '0;
		items_ch.x_null = 1'b0;
		items_ch.y_null = 1'b0;
		items_ch.last_element = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_vectors();
		set_metric(MET_MANHATTAN);
		directed_vectors();
		set_metric(2'd2);
		pearson_vectors();
		set_metric(2'd3);
		pearson_vectors();

		set_metric(MET_EUCLID);
		hold_req = 1'b1;
		random_vectors(150);
		set_metric(2'd2);
		random_vectors(150);
		// overlong vector runs past the element limit
		for (int i = 0; i < 1030; i++)
			put_pair(pick_value(), pick_value(), 0, 0, i == 1029);
		set_metric(MET_MANHATTAN);
		random_vectors(120);
		set_metric(2'd3);
		random_vectors(60);
		set_metric(MET_EUCLID);
		random_vectors(60);
		items_ch.valid <= 1'b0;

		while (outstanding != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("masked_vector_distance regression: pass");
		else
			$display("masked_vector_distance regression: fail");
		$finish;
	end
endmodule
